FILE: sv/bpfm_pkg.sv
// Package with shared constants and types of the buffer pool frame manager.
`timescale 1ns / 1ps
package bpfm_pkg;
    localparam int NUM_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 24;
    localparam int PIN_BITS_DEF   = 8;

    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;
    localparam int FIDX_W  = 4;
    localparam int WPAGE_W = 24;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [OP_W-1:0] OP_PIN   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNPIN = 3'd1;
    localparam logic [OP_W-1:0] OP_DIRTY = 3'd2;
    localparam logic [OP_W-1:0] OP_FORCE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISSING  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_FRAME = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNPINNED = 3'd3;
    localparam logic [STAT_W-1:0] ST_PIN_FULL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FIDX_W-1:0]  frame_index;
        logic               write_back;
        logic [WPAGE_W-1:0] write_page;
        logic               fetch;
        logic [CNT_W-1:0]   read_total;
        logic [CNT_W-1:0]   write_total;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [31:0]     page_number;
    } t_request;
endpackage

FILE: sv/bpfm_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps
interface bpfm_req_if;
    logic                       valid;
    logic                       ready;
    logic [bpfm_pkg::OP_W-1:0]  operation;
    logic [23:0]                page_number;
    modport source (output valid, operation, page_number, input ready);
    modport sink   (input valid, operation, page_number, output ready);
endinterface

interface bpfm_res_if;
    logic                          valid;
    logic                          ready;
    logic [bpfm_pkg::STAT_W-1:0]   status;
    logic [bpfm_pkg::FIDX_W-1:0]   frame_index;
    logic                          write_back;
    logic [bpfm_pkg::WPAGE_W-1:0]  write_page;
    logic                          fetch;
    logic [bpfm_pkg::CNT_W-1:0]    read_total;
    logic [bpfm_pkg::CNT_W-1:0]    write_total;
    logic                          last;
    modport source (output valid, status, frame_index, write_back, write_page, fetch,
                    read_total, write_total, last, input ready);
    modport sink   (input valid, status, frame_index, write_back, write_page, fetch,
                    read_total, write_total, last, output ready);
endinterface

interface bpfm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bpfm_pkg::CFG_IDX_W-1:0]    index;
    logic [bpfm_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/buffer_pool_frame_manager.sv
// Top level of the buffer pool frame manager.
`timescale 1ns / 1ps
// Frame table of a page buffer pool with FIFO or LRU replacement.
// Requests arrive on req (operation, page_number); results leave on res, one
// per request except flush all, which gives one per written frame (or one
// empty result if none is written). The field last marks the final result of
// a request. Configuration is written on cfg: index 0 selects the policy,
// index 1 the number of active frames. A request is handled by a sequencer
// that walks the frames one at a time: a lookup pass over the active frames,
// for a pin miss a second pass that picks an empty frame or a victim with the
// shared stamp comparator, then an update. Page numbers and stamps live in
// single-port RAMs, so each frame visit has an address state and a registered
// data state. The result is registered in the same cycle as req becomes ready
// again. req is not ready while a request is in work. A result is held in an
// output register; when the receiver stalls, the sequencer waits on it.
// Reset clears valid, dirty and pin state, the counters and configuration
// (FIFO, all frames active); the RAMs need no clearing.
module buffer_pool_frame_manager #(
    parameter int NUM_FRAMES = bpfm_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = bpfm_pkg::PAGE_BITS_DEF,
    parameter int PIN_BITS   = bpfm_pkg::PIN_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bpfm_req_if.sink   req,
    bpfm_res_if.source res,
    bpfm_cfg_if.sink   cfg
);
    import bpfm_pkg::*;

    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int NW = $clog2(NUM_FRAMES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LADDR = 4'd1;
    localparam logic [3:0] S_LDATA = 4'd2;
    localparam logic [3:0] S_DECID = 4'd3;
    localparam logic [3:0] S_VADDR = 4'd4;
    localparam logic [3:0] S_VDATA = 4'd5;
    localparam logic [3:0] S_VREAD = 4'd6;
    localparam logic [3:0] S_VPAGE = 4'd7;
    localparam logic [3:0] S_LOAD  = 4'd8;
    localparam logic [3:0] S_FADDR = 4'd9;
    localparam logic [3:0] S_FDATA = 4'd10;
    localparam logic [3:0] S_FEND  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]            r_state;
    logic                  r_policy;
    logic [4:0]            r_frames;
    logic [NUM_FRAMES-1:0] r_valid, r_dirty;
    logic [PIN_BITS-1:0]   r_pins [NUM_FRAMES];
    logic [CNT_W-1:0]      r_rd_cnt, r_wr_cnt, r_acc_cnt;
    logic [OP_W-1:0]       r_op;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FW-1:0]         r_idx;
    logic                  r_found;
    logic [FW-1:0]         r_hit;
    logic                  r_best_ok;
    logic [FW-1:0]         r_best;
    logic [CNT_W-1:0]      r_best_stamp;
    logic                  r_any;
    logic                  r_res_valid;
    t_result               r_res;
    t_result               r_fl;

    // RAM ports.
    logic                  page_we, load_we, use_we;
    logic [FW-1:0]         ram_addr;
    logic [PAGE_BITS-1:0]  page_rd;
    logic [CNT_W-1:0]      load_rd, use_rd, load_wd, use_wd;

    bpfm_ram #(.WIDTH(PAGE_BITS), .DEPTH(1 << FW)) u_page (
        .i_clk(i_clk), .i_we(page_we), .i_addr(ram_addr), .i_wdata(r_page),
        .o_rdata(page_rd));
    bpfm_ram #(.WIDTH(CNT_W), .DEPTH(1 << FW)) u_load (
        .i_clk(i_clk), .i_we(load_we), .i_addr(ram_addr), .i_wdata(load_wd),
        .o_rdata(load_rd));
    bpfm_ram #(.WIDTH(CNT_W), .DEPTH(1 << FW)) u_use (
        .i_clk(i_clk), .i_we(use_we), .i_addr(ram_addr), .i_wdata(use_wd),
        .o_rdata(use_rd));

    // Active frame count, clamped to 1..NUM_FRAMES.
    logic [NW-1:0] active_n;
    always_comb begin
        if (r_frames == 5'd0) begin
            active_n = NW'(1);
        end else if (32'(r_frames) > NUM_FRAMES) begin
            active_n = NW'(NUM_FRAMES);
        end else begin
            active_n = NW'(r_frames);
        end
    end
    logic idx_last;
    assign idx_last = ((NW + 1)'(r_idx) + (NW + 1)'(1)) >= (NW + 1)'(active_n);

    logic [CNT_W-1:0] stamp_rd;
    logic             stamp_less;
    assign stamp_rd   = r_policy ? use_rd : load_rd;
    assign stamp_less = !r_best_ok || (stamp_rd < r_best_stamp);

    logic [CNT_W-1:0] rd_inc;
    assign rd_inc  = r_rd_cnt + CNT_W'(1);
    assign load_wd = rd_inc;
    assign use_wd  = r_acc_cnt + CNT_W'(1);

    // The held flush result, marked as the final one of the request.
    t_result fl_last;
    always_comb begin
        fl_last      = r_fl;
        fl_last.last = 1'b1;
    end

    assign req.ready = (r_state == S_IDLE);
    assign cfg.ready = 1'b1;
    assign res.valid = r_res_valid;
    assign res.status      = r_res.status;
    assign res.frame_index = r_res.frame_index;
    assign res.write_back  = r_res.write_back;
    assign res.write_page  = r_res.write_page;
    assign res.fetch       = r_res.fetch;
    assign res.read_total  = r_res.read_total;
    assign res.write_total = r_res.write_total;
    assign res.last        = r_res.last;

    logic out_free;
    assign out_free = !r_res_valid || res.ready;

    // RAM address and write strobes follow the sequencer.
    always_comb begin
        ram_addr = r_idx;
        page_we  = 1'b0;
        load_we  = 1'b0;
        use_we   = 1'b0;
        if (r_state == S_VPAGE) begin
            ram_addr = r_best;
        end else if (r_state == S_LOAD) begin
            ram_addr = r_best;
            page_we  = out_free;
            load_we  = out_free;
            use_we   = out_free;
        end else if (r_state == S_DECID) begin
            ram_addr = r_hit;
            use_we   = (r_op == OP_PIN) && r_found && (r_pins[r_hit] != {PIN_BITS{1'b1}});
        end
    end

    function automatic t_result mk(input logic [STAT_W-1:0] st, input logic [FW-1:0] f,
                                   input logic wb, input logic [PAGE_BITS-1:0] wp,
                                   input logic fe, input logic [CNT_W-1:0] rc,
                                   input logic [CNT_W-1:0] wc, input logic la);
        t_result r;
        r.status      = st;
        r.frame_index = FIDX_W'(f);
        r.write_back  = wb;
        r.write_page  = wb ? WPAGE_W'(wp) : '0;
        r.fetch       = fe;
        r.read_total  = rc;
        r.write_total = wc;
        r.last        = la;
        return r;
    endfunction

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= 1'b0;
            r_frames    <= 5'd16;
            r_valid     <= '0;
            r_dirty     <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) r_pins[i] <= '0;
            r_rd_cnt    <= '0;
            r_wr_cnt    <= '0;
            r_acc_cnt   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && res.ready) begin
                r_res_valid <= 1'b0;
            end
            if (cfg.valid) begin
                if (cfg.index == REG_POLICY) begin
                    r_policy <= cfg.data[0];
                end else begin
                    r_frames <= cfg.data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (req.valid) begin
                        r_op      <= req.operation;
                        r_page    <= PAGE_BITS'(req.page_number);
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_hit     <= '0;
                        r_best_ok <= 1'b0;
                        r_best    <= '0;
                        r_any     <= 1'b0;
                        if (req.operation == OP_FLUSH) begin
                            r_state <= S_FADDR;
                        end else if (req.operation > OP_FLUSH) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_LADDR;
                        end
                    end
                end
                S_LADDR: r_state <= S_LDATA;
                S_LDATA: begin
                    if (!r_found && r_valid[r_idx] && page_rd == r_page) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx;
                    end
                    if (idx_last) begin
                        r_state <= S_DECID;
                    end else begin
                        r_idx   <= r_idx + FW'(1);
                        r_state <= S_LADDR;
                    end
                end
                S_DECID: begin
                    // A pin miss goes on to the victim scan; the rest update here.
                    if (!r_found && r_op == OP_PIN) begin
                        r_idx   <= '0;
                        r_state <= S_VADDR;
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                        r_res_valid <= 1'b1;
                        if (!r_found) begin
                            r_res <= mk(ST_MISSING, '0, 1'b0, '0, 1'b0, r_rd_cnt,
                                        r_wr_cnt, 1'b1);
                        end else begin
                            case (r_op)
                                OP_PIN: begin
                                    if (r_pins[r_hit] == {PIN_BITS{1'b1}}) begin
                                        r_res <= mk(ST_PIN_FULL, r_hit, 1'b0, '0, 1'b0,
                                                    r_rd_cnt, r_wr_cnt, 1'b1);
                                    end else begin
                                        r_pins[r_hit] <= r_pins[r_hit] + PIN_BITS'(1);
                                        r_acc_cnt <= use_wd;
                                        r_res <= mk(ST_OK, r_hit, 1'b0, '0, 1'b0,
                                                    r_rd_cnt, r_wr_cnt, 1'b1);
                                    end
                                end
                                OP_UNPIN: begin
                                    if (r_pins[r_hit] == '0) begin
                                        r_res <= mk(ST_UNPINNED, r_hit, 1'b0, '0, 1'b0,
                                                    r_rd_cnt, r_wr_cnt, 1'b1);
                                    end else begin
                                        r_pins[r_hit] <= r_pins[r_hit] - PIN_BITS'(1);
                                        r_res <= mk(ST_OK, r_hit, 1'b0, '0, 1'b0,
                                                    r_rd_cnt, r_wr_cnt, 1'b1);
                                    end
                                end
                                OP_DIRTY: begin
                                    r_dirty[r_hit] <= 1'b1;
                                    r_res <= mk(ST_OK, r_hit, 1'b0, '0, 1'b0, r_rd_cnt,
                                                r_wr_cnt, 1'b1);
                                end
                                default: begin
                                    // Force page: write always, clear dirty.
                                    r_dirty[r_hit] <= 1'b0;
                                    r_wr_cnt <= r_wr_cnt + CNT_W'(1);
                                    r_res <= mk(ST_OK, r_hit, 1'b1, r_page, 1'b0,
                                                r_rd_cnt, r_wr_cnt + CNT_W'(1), 1'b1);
                                end
                            endcase
                        end
                    end
                end
                S_VADDR: r_state <= S_VDATA;
                S_VDATA: begin
                    // Empty frame wins outright; else the shared stamp compare.
                    if (!r_any) begin
                        if (!r_valid[r_idx]) begin
                            r_any  <= 1'b1;
                            r_best_ok <= 1'b1;
                            r_best <= r_idx;
                        end else if (r_pins[r_idx] == '0 && stamp_less) begin
                            r_best_ok    <= 1'b1;
                            r_best       <= r_idx;
                            r_best_stamp <= stamp_rd;
                        end
                    end
                    if (idx_last) begin
                        r_state <= S_VREAD;
                    end else begin
                        r_idx   <= r_idx + FW'(1);
                        r_state <= S_VADDR;
                    end
                end
                S_VREAD: begin
                    if (!r_best_ok) begin
                        if (out_free) begin
                            r_res <= mk(ST_NO_FRAME, '0, 1'b0, '0, 1'b0, r_rd_cnt,
                                        r_wr_cnt, 1'b1);
                            r_res_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_VPAGE;
                    end
                end
                S_VPAGE: r_state <= S_LOAD;
                S_LOAD: begin
                    if (out_free) begin
                        r_valid[r_best] <= 1'b1;
                        r_dirty[r_best] <= 1'b0;
                        r_pins[r_best]  <= PIN_BITS'(1);
                        r_rd_cnt  <= rd_inc;
                        r_acc_cnt <= use_wd;
                        if (r_valid[r_best] && r_dirty[r_best]) begin
                            r_wr_cnt <= r_wr_cnt + CNT_W'(1);
                            r_res <= mk(ST_OK, r_best, 1'b1, page_rd, 1'b1, rd_inc,
                                        r_wr_cnt + CNT_W'(1), 1'b1);
                        end else begin
                            r_res <= mk(ST_OK, r_best, 1'b0, '0, 1'b1, rd_inc,
                                        r_wr_cnt, 1'b1);
                        end
                        r_res_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_FADDR: r_state <= S_FDATA;
                S_FDATA: begin
                    // A flush result is held until the next dirty frame or the end
                    // of the scan is known, so that last can still be set on it.
                    if (r_valid[r_idx] && r_dirty[r_idx] && r_pins[r_idx] == '0) begin
                        if (!r_any || out_free) begin
                            r_dirty[r_idx] <= 1'b0;
                            r_wr_cnt <= r_wr_cnt + CNT_W'(1);
                            r_any <= 1'b1;
                            r_fl <= mk(ST_OK, r_idx, 1'b1, page_rd, 1'b0, r_rd_cnt,
                                       r_wr_cnt + CNT_W'(1), 1'b0);
                            if (r_any) begin
                                r_res       <= r_fl;
                                r_res_valid <= 1'b1;
                            end
                            r_state <= S_FEND;
                        end
                    end else begin
                        r_state <= S_FEND;
                    end
                end
                S_FEND: begin
                    // Release the held result as last, or give the empty result.
                    if (idx_last) begin
                        if (out_free) begin
                            if (r_any) begin
                                r_res <= fl_last;
                            end else begin
                                r_res <= mk(ST_OK, '0, 1'b0, '0, 1'b0, r_rd_cnt,
                                            r_wr_cnt, 1'b1);
                            end
                            r_res_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= r_idx + FW'(1);
                        r_state <= S_FADDR;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_res <= mk(ST_OK, '0, 1'b0, '0, 1'b0, r_rd_cnt, r_wr_cnt, 1'b1);
                        r_res_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/bpfm_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module bpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Registered read; a write returns the old data at that address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: verif/bpfm_tb_if.sv
// Package with the request record of the testbench.
`timescale 1ns / 1ps
package bpfm_tb_pkg;
    import bpfm_pkg::*;

    // One pending request for the driver.
    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [23:0]     page_number;
    } t_pool_req;
endpackage

FILE: verif/tb.sv
// Self-checking testbench of the buffer pool frame manager with a frame table predictor.
`timescale 1ns / 1ps
module tb;
    import bpfm_pkg::*;
    import bpfm_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpfm_req_if req ();
    bpfm_res_if res ();
    bpfm_cfg_if cfg ();

    buffer_pool_frame_manager dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .req    (req.sink),
        .res    (res.source),
        .cfg    (cfg.sink)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: a private copy of the frame table.
    logic [23:0] tbl_page  [16];
    logic        tbl_valid [16];
    logic        tbl_dirty [16];
    logic [7:0]  tbl_pins  [16];
    logic [31:0] tbl_load  [16];
    logic [31:0] tbl_use   [16];
    logic [31:0] reads_done, writes_done, accesses;
    logic        lru_mode;
    logic [4:0]  active_reg;

    t_pool_req pending_reqs[$];
    t_result   expected_results[$];
    int        errors = 0;
    int        send_idle_pct = 22;
    int        recv_idle_pct = 51;
    bit        hold_off = 1'b0;
    logic [23:0] recent_pages[$];

    function automatic int active_frames();
        if (active_reg == 0) return 1;
        if (active_reg > 16) return 16;
        return active_reg;
    endfunction

    function automatic int find_page(logic [23:0] pg);
        for (int i = 0; i < active_frames(); i++)
            if (tbl_valid[i] && tbl_page[i] == pg) return i;
        return -1;
    endfunction

    function automatic void push_result(logic [2:0] st, int fr, logic wb,
                                        logic [23:0] wpg, logic ft, logic lst);
        t_result r;
        r.status = st;
        r.frame_index = fr[3:0];
        r.write_back = wb;
        r.write_page = wb ? wpg : '0;
        r.fetch = ft;
        r.read_total = reads_done;
        r.write_total = writes_done;
        r.last = lst;
        expected_results.push_back(r);
    endfunction

    // Work out the results of one accepted request and update the table.
    function automatic void predict_request(t_pool_req rq);
        int f;
        int n;
        int k;
        logic [31:0] best;
        logic [31:0] s;
        logic wb;
        logic [23:0] wpg;
        n = active_frames();
        f = find_page(rq.page_number);
        case (rq.operation)
            OP_PIN: begin
                if (f >= 0) begin
                    if (tbl_pins[f] == 8'hFF) begin
                        push_result(ST_PIN_FULL, f, 1'b0, 24'h0, 1'b0, 1'b1);
                    end else begin
                        tbl_pins[f]++;
                        accesses++;
                        tbl_use[f] = accesses;
                        push_result(ST_OK, f, 1'b0, 24'h0, 1'b0, 1'b1);
                    end
                end else begin
                    for (int i = 0; i < n && f < 0; i++)
                        if (!tbl_valid[i]) f = i;
                    if (f < 0) begin
                        best = '0;
                        for (int i = 0; i < n; i++) begin
                            if (tbl_pins[i] != 0) continue;
                            s = lru_mode ? tbl_use[i] : tbl_load[i];
                            if (f < 0 || s < best) begin
                                best = s;
                                f = i;
                            end
                        end
                    end
                    if (f < 0) begin
                        push_result(ST_NO_FRAME, 0, 1'b0, 24'h0, 1'b0, 1'b1);
                    end else begin
                        wb = 1'b0;
                        wpg = '0;
                        if (tbl_valid[f] && tbl_dirty[f]) begin
                            wb = 1'b1;
                            wpg = tbl_page[f];
                            writes_done++;
                        end
                        reads_done++;
                        accesses++;
                        tbl_page[f] = rq.page_number;
                        tbl_valid[f] = 1'b1;
                        tbl_dirty[f] = 1'b0;
                        tbl_pins[f] = 8'd1;
                        tbl_load[f] = reads_done;
                        tbl_use[f] = accesses;
                        push_result(ST_OK, f, wb, wpg, 1'b1, 1'b1);
                    end
                end
            end
            OP_UNPIN: begin
                if (f < 0) push_result(ST_MISSING, 0, 1'b0, 24'h0, 1'b0, 1'b1);
                else if (tbl_pins[f] == 0) push_result(ST_UNPINNED, f, 1'b0, 24'h0, 1'b0, 1'b1);
                else begin
                    tbl_pins[f]--;
                    push_result(ST_OK, f, 1'b0, 24'h0, 1'b0, 1'b1);
                end
            end
            OP_DIRTY: begin
                if (f < 0) push_result(ST_MISSING, 0, 1'b0, 24'h0, 1'b0, 1'b1);
                else begin
                    tbl_dirty[f] = 1'b1;
                    push_result(ST_OK, f, 1'b0, 24'h0, 1'b0, 1'b1);
                end
            end
            OP_FORCE: begin
                if (f < 0) push_result(ST_MISSING, 0, 1'b0, 24'h0, 1'b0, 1'b1);
                else begin
                    writes_done++;
                    tbl_dirty[f] = 1'b0;
                    push_result(ST_OK, f, 1'b1, tbl_page[f], 1'b0, 1'b1);
                end
            end
            OP_FLUSH: begin
                k = 0;
                for (int i = 0; i < n; i++) begin
                    if (tbl_valid[i] && tbl_dirty[i] && tbl_pins[i] == 0) begin
                        writes_done++;
                        tbl_dirty[i] = 1'b0;
                        push_result(ST_OK, i, 1'b1, tbl_page[i], 1'b0, 1'b0);
                        k++;
                    end
                end
                if (k == 0) push_result(ST_OK, 0, 1'b0, 24'h0, 1'b0, 1'b1);
                else expected_results[$].last = 1'b1;
            end
            default: push_result(ST_OK, 0, 1'b0, 24'h0, 1'b0, 1'b1);
        endcase
    endfunction

    // Driver: offers the oldest pending request, predicts on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            req.operation <= '0;
            req.page_number <= '0;
        end else begin
            if (req.valid && req.ready) begin
                predict_request(t_pool_req'{req.operation, req.page_number});
                void'(pending_reqs.pop_front());
            end
            if ((!req.valid || req.ready) && !hold_off && pending_reqs.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                req.valid <= 1'b1;
                req.operation <= pending_reqs[0].operation;
                req.page_number <= pending_reqs[0].page_number;
            end else if (!req.valid || req.ready) begin
                req.valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                got = t_result'{res.status, res.frame_index, res.write_back, res.write_page,
                                res.fetch, res.read_total, res.write_total, res.last};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                    end
                end
            end
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_POLICY) lru_mode = val[0];
        else active_reg = val;
    endtask

    task automatic add_req(logic [2:0] op, logic [23:0] pg);
        pending_reqs.push_back(t_pool_req'{op, pg});
    endtask

    function automatic logic [23:0] pick_page();
        if (recent_pages.size() > 0 && $urandom_range(99) < 75)
            return recent_pages[$urandom_range(recent_pages.size() - 1)];
        return 24'($urandom);
    endfunction

    // Random phase: mostly single pin, unpin, dirty and force requests over a small working set.
    task automatic random_phase(int count);
        logic [23:0] pg;
        recent_pages.delete();
        for (int i = 0; i < 24; i++) recent_pages.push_back(24'($urandom));
        for (int i = 0; i < count; i++) begin
            pg = pick_page();
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: add_req(OP_PIN, pg);
                7, 8, 9, 10, 11:     add_req(OP_UNPIN, pg);
                12, 13, 14:          add_req(OP_DIRTY, pg);
                15, 16:              add_req(OP_FORCE, pg);
                17:                  add_req(OP_FLUSH, 24'($urandom));
                18:                  add_req(3'($urandom_range(7)), 24'($urandom));
                default: begin
                    add_req(OP_PIN, pg);
                    add_req(OP_DIRTY, pg);
                    add_req(OP_UNPIN, pg);
                end
            endcase
        end
    endtask

    initial begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        for (int i = 0; i < 16; i++) begin
            tbl_page[i] = '0; tbl_valid[i] = 0; tbl_dirty[i] = 0;
            tbl_pins[i] = '0; tbl_load[i] = '0; tbl_use[i] = '0;
        end
        reads_done = '0; writes_done = '0; accesses = '0;
        lru_mode = 1'b0; active_reg = 5'd16;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes, every operation, pool exhaustion, bad codes.
        write_reg(REG_FRAMES, 5'd2);
        add_req(OP_UNPIN, 24'h000000);
        add_req(OP_PIN, 24'h000000);
        add_req(OP_PIN, 24'hFFFFFF);
        add_req(OP_PIN, 24'h5A5A5A);
        add_req(OP_UNPIN, 24'hFFFFFF);
        add_req(OP_UNPIN, 24'hFFFFFF);
        add_req(OP_DIRTY, 24'hFFFFFF);
        add_req(OP_PIN, 24'hA5A5A5);
        add_req(OP_FORCE, 24'hA5A5A5);
        add_req(OP_FORCE, 24'h123456);
        add_req(OP_DIRTY, 24'h000000);
        add_req(OP_UNPIN, 24'h000000);
        add_req(OP_UNPIN, 24'hA5A5A5);
        add_req(OP_FLUSH, 24'hFFFFFF);
        add_req(OP_FLUSH, 24'h0);
        add_req(3'd5, 24'h0); add_req(3'd6, 24'hFFFFFF); add_req(3'd7, 24'h1);
        add_req(OP_DIRTY, 24'h777777);
        wait_drained();

        // Pin count saturation on one frame; it stays pinned afterwards.
        write_reg(REG_FRAMES, 5'd1);
        write_reg(REG_POLICY, 5'd1);
        for (int i = 0; i < 256; i++) add_req(OP_PIN, 24'h000000);
        for (int i = 0; i < 2; i++) add_req(OP_UNPIN, 24'h000000);
        wait_drained();

        // Random phases across settings and idling modes.
        write_reg(REG_FRAMES, 5'd0);
        random_phase(20);
        wait_drained();
        write_reg(REG_FRAMES, 5'd16);
        write_reg(REG_POLICY, 5'd0);
        random_phase(45);
        // Sender holds off until everything in flight has come back.
        while (pending_reqs.size() > 20) @(posedge i_clk);
        hold_off = 1'b1;
        while (req.valid || expected_results.size() > 0) @(posedge i_clk);
        hold_off = 1'b0;
        wait_drained();
        write_reg(REG_FRAMES, 5'd31);
        write_reg(REG_POLICY, 5'd1);
        send_idle_pct = 51; recv_idle_pct = 22;
        random_phase(45);
        wait_drained();
        write_reg(REG_FRAMES, 5'd5);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(40);
        wait_drained();
        write_reg(REG_FRAMES, 5'd16);
        write_reg(REG_POLICY, 5'd0);
        random_phase(30);
        wait_drained();

        if (errors == 0) $display("buffer_pool_frame_manager test passed");
        else $display("buffer_pool_frame_manager test failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("buffer_pool_frame_manager test failed");
        $finish;
    end
endmodule

FILE: sim.f
sv/bpfm_pkg.sv
sv/bpfm_if.sv
sv/bpfm_ram.sv
sv/buffer_pool_frame_manager.sv
verif/bpfm_tb_if.sv
verif/tb.sv
